FILE: rtl/core/calclk_pkg.sv
// ----------------------------------------------------------------------------
// calclk_pkg
// Shared types, constants and calendar helper functions for the calendar
// clock with key setting.
// ----------------------------------------------------------------------------
package calclk_pkg;

  // Field widths.
  localparam int unsigned RATE_W  = 8;
  localparam int unsigned KEYS_W  = 4;
  localparam int unsigned SEC_W   = 6;
  localparam int unsigned MIN_W   = 6;
  localparam int unsigned HOUR_W  = 5;
  localparam int unsigned DAY_W   = 5;
  localparam int unsigned MONTH_W = 4;
  localparam int unsigned FIELD_W = 3;
  localparam int unsigned MODE_W  = 2;

  // Opcodes of an input beat.
  localparam logic OP_TICK = 1'b0;
  localparam logic OP_KEYS = 1'b1;

  // Key bit positions.
  localparam int unsigned KEY_UP     = 0;
  localparam int unsigned KEY_DOWN   = 1;
  localparam int unsigned KEY_SELECT = 2;
  localparam int unsigned KEY_MODE   = 3;

  // Selected field codes.
  localparam logic [FIELD_W-1:0] FIELD_RUN   = 3'd0;
  localparam logic [FIELD_W-1:0] FIELD_SEC   = 3'd1;
  localparam logic [FIELD_W-1:0] FIELD_MIN   = 3'd2;
  localparam logic [FIELD_W-1:0] FIELD_HOUR  = 3'd3;
  localparam logic [FIELD_W-1:0] FIELD_DAY   = 3'd4;
  localparam logic [FIELD_W-1:0] FIELD_MONTH = 3'd5;

  // Limits.
  localparam logic [SEC_W-1:0]   SEC_MAX   = 6'd59;
  localparam logic [MIN_W-1:0]   MIN_MAX   = 6'd59;
  localparam logic [HOUR_W-1:0]  HOUR_MAX  = 5'd23;
  localparam logic [MONTH_W-1:0] MONTH_MAX = 4'd12;
  localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_APR = 4'd4;
  localparam logic [MONTH_W-1:0] MONTH_JUN = 4'd6;
  localparam logic [MONTH_W-1:0] MONTH_SEP = 4'd9;
  localparam logic [MONTH_W-1:0] MONTH_NOV = 4'd11;
  localparam logic [DAY_W-1:0]   LEN_SHORT = 5'd28;
  localparam logic [DAY_W-1:0]   LEN_MID   = 5'd30;
  localparam logic [DAY_W-1:0]   LEN_LONG  = 5'd31;

  // Reset values.
  localparam logic [RATE_W-1:0]  RATE_RST  = 8'd2;
  localparam logic [SEC_W-1:0]   SEC_RST   = 6'd0;
  localparam logic [MIN_W-1:0]   MIN_RST   = 6'd14;
  localparam logic [HOUR_W-1:0]  HOUR_RST  = 5'd9;
  localparam logic [DAY_W-1:0]   DAY_RST   = 5'd16;
  localparam logic [MONTH_W-1:0] MONTH_RST = 4'd12;

  typedef struct packed {
    logic [RATE_W-1:0]  tick_count;
    logic [SEC_W-1:0]   sec;
    logic [MIN_W-1:0]   min;
    logic [HOUR_W-1:0]  hour;
    logic [DAY_W-1:0]   day;
    logic [MONTH_W-1:0] month;
    logic [FIELD_W-1:0] field;
    logic [MODE_W-1:0]  mode;
    logic [KEYS_W-1:0]  prev_keys;
  } cal_state_t;

  // Days in a month; anything outside 1..12 counts as a long month.
  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m);
    logic [DAY_W-1:0] len;
    if (m == MONTH_FEB) begin
      len = LEN_SHORT;
    end else if (m == MONTH_APR || m == MONTH_JUN || m == MONTH_SEP || m == MONTH_NOV) begin
      len = LEN_MID;
    end else begin
      len = LEN_LONG;
    end
    return len;
  endfunction

  function automatic logic [MONTH_W-1:0] month_inc(input logic [MONTH_W-1:0] m);
    return (m >= MONTH_MAX) ? MONTH_W'(1) : m + MONTH_W'(1);
  endfunction

endpackage

FILE: rtl/core/calclk_step.sv
// ----------------------------------------------------------------------------
// calclk_step
// Next-state logic: applies one tick or key sample to the calendar state.
// ----------------------------------------------------------------------------
module calclk_step (
  input  calclk_pkg::cal_state_t              cur,
  input  logic                                opcode,
  input  logic [calclk_pkg::KEYS_W-1:0]       keys,
  input  logic [calclk_pkg::RATE_W-1:0]       ticks_per_second,
  output calclk_pkg::cal_state_t              nxt
);
  import calclk_pkg::*;

  logic [RATE_W:0]    cnt_inc;
  logic [KEYS_W-1:0]  rel;
  logic [DAY_W-1:0]   day_inc;
  logic               day_wrap;
  logic               step_up;
  logic [MONTH_W-1:0] mon_new;
  logic [DAY_W-1:0]   mon_len;

  assign cnt_inc  = {1'b0, cur.tick_count} + (RATE_W+1)'(1);
  assign rel      = cur.prev_keys & ~keys;
  assign day_inc  = cur.day + DAY_W'(1);
  assign day_wrap = (day_inc > month_len(cur.month)) || (day_inc == '0);
  assign step_up  = rel[KEY_UP];

  // Month after a month step, and its length for the day clamp.
  always_comb begin
    if (step_up) begin
      mon_new = month_inc(cur.month);
    end else if (cur.month <= MONTH_W'(1) || cur.month > MONTH_MAX) begin
      mon_new = MONTH_MAX;
    end else begin
      mon_new = cur.month - MONTH_W'(1);
    end
    mon_len = month_len(mon_new);
  end

  always_comb begin
    nxt = cur;
    if (opcode == OP_TICK) begin
      if (cur.field == FIELD_RUN) begin
        if (cnt_inc < {1'b0, ticks_per_second}) begin
          nxt.tick_count = cnt_inc[RATE_W-1:0];
        end else begin
          nxt.tick_count = '0;
          if (cur.sec != SEC_MAX) begin
            nxt.sec = cur.sec + SEC_W'(1);
          end else begin
            nxt.sec = '0;
            if (cur.min != MIN_MAX) begin
              nxt.min = cur.min + MIN_W'(1);
            end else begin
              nxt.min = '0;
              if (cur.hour != HOUR_MAX) begin
                nxt.hour = cur.hour + HOUR_W'(1);
              end else begin
                nxt.hour = '0;
                if (day_wrap) begin
                  nxt.day   = DAY_W'(1);
                  nxt.month = month_inc(cur.month);
                end else begin
                  nxt.day = day_inc;
                end
              end
            end
          end
        end
      end
    end else begin
      nxt.prev_keys = keys;
      priority if (rel[KEY_UP] || rel[KEY_DOWN]) begin
        unique case (cur.field)
          FIELD_SEC: begin
            if (step_up) nxt.sec = (cur.sec >= SEC_MAX) ? '0 : cur.sec + SEC_W'(1);
            else         nxt.sec = (cur.sec == '0) ? SEC_MAX : cur.sec - SEC_W'(1);
          end
          FIELD_MIN: begin
            if (step_up) nxt.min = (cur.min >= MIN_MAX) ? '0 : cur.min + MIN_W'(1);
            else         nxt.min = (cur.min == '0) ? MIN_MAX : cur.min - MIN_W'(1);
          end
          FIELD_HOUR: begin
            if (step_up) nxt.hour = (cur.hour >= HOUR_MAX) ? '0 : cur.hour + HOUR_W'(1);
            else         nxt.hour = (cur.hour == '0) ? HOUR_MAX : cur.hour - HOUR_W'(1);
          end
          FIELD_DAY: begin
            if (step_up) begin
              if (day_wrap) begin
                nxt.day   = DAY_W'(1);
                nxt.month = month_inc(cur.month);
              end else begin
                nxt.day = day_inc;
              end
            end else begin
              nxt.day = (cur.day <= DAY_W'(1)) ? month_len(cur.month) : cur.day - DAY_W'(1);
            end
          end
          FIELD_MONTH: begin
            nxt.month = mon_new;
            if (cur.day > mon_len) nxt.day = mon_len;
          end
          default: begin
          end
        endcase
      end else if (rel[KEY_SELECT]) begin
        nxt.field = (cur.field >= FIELD_MONTH) ? FIELD_RUN : cur.field + FIELD_W'(1);
      end else if (rel[KEY_MODE]) begin
        nxt.mode = cur.mode + MODE_W'(1);
      end else begin
        // No key was released; only the key levels are remembered.
      end
    end
  end

endmodule

FILE: rtl/core/calendar_clock_with_key_setting_top.sv
// A beat passes through the input register, then the state register.
// Throughput: one beat per cycle while out_ready is high; the calendar update
// is a single pass of next-state logic between the input and state registers.
// Reset (rst_n low, synchronous): 09:14:00 on December 16, running, clock
// display, tick rate 2, no keys held, both pipeline stages empty.
// ----------------------------------------------------------------------------
// calendar_clock_with_key_setting_top
// Calendar clock with tick counting, key-driven setting and display mode.
// ----------------------------------------------------------------------------
module calendar_clock_with_key_setting_top (
  input  logic                                clk,
  input  logic                                rst_n,
  // Configuration: ticks counted per seconds advance.
  input  logic                                cfg_wr_en,
  input  logic [calclk_pkg::RATE_W-1:0]       cfg_wr_data,
  // Input channel.
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_opcode,
  input  logic [calclk_pkg::KEYS_W-1:0]       in_keys,
  // Result channel.
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [calclk_pkg::SEC_W-1:0]        out_seconds,
  output logic [calclk_pkg::MIN_W-1:0]        out_minutes,
  output logic [calclk_pkg::HOUR_W-1:0]       out_hours,
  output logic [calclk_pkg::DAY_W-1:0]        out_day_of_month,
  output logic [calclk_pkg::MONTH_W-1:0]      out_month_number,
  output logic [calclk_pkg::FIELD_W-1:0]      out_set_field,
  output logic [calclk_pkg::MODE_W-1:0]       out_display_mode,
  output logic                                out_running
);
  import calclk_pkg::*;

  // Input register: one beat waiting to be applied to the calendar.
  logic                 s1_valid_r;
  logic                 s1_opcode_r;
  logic [KEYS_W-1:0]    s1_keys_r;

  // Calendar state. It only changes when a result beat is loaded, so it
  // doubles as the result register: a waiting beat always shows the state
  // right after its own update.
  cal_state_t           state_r;
  cal_state_t           state_nxt;
  logic [RATE_W-1:0]    rate_r;
  logic                 out_valid_r;

  logic                 advance;

  // The result slot is free when empty or being emptied this cycle.
  assign advance  = s1_valid_r && (!out_valid_r || out_ready);
  // The input register refills whenever its beat moves on.
  assign in_ready = !s1_valid_r || advance;

  calclk_step u_step (
    .cur              (state_r),
    .opcode           (s1_opcode_r),
    .keys             (s1_keys_r),
    .ticks_per_second (rate_r),
    .nxt              (state_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  // Payload of the input register needs no reset.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_opcode_r <= in_opcode;
      s1_keys_r   <= in_keys;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.tick_count <= '0;
      state_r.sec        <= SEC_RST;
      state_r.min        <= MIN_RST;
      state_r.hour       <= HOUR_RST;
      state_r.day        <= DAY_RST;
      state_r.month      <= MONTH_RST;
      state_r.field      <= FIELD_RUN;
      state_r.mode       <= '0;
      state_r.prev_keys  <= '0;
    end else if (advance) begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_r <= RATE_RST;
    end else if (cfg_wr_en) begin
      rate_r <= cfg_wr_data;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_seconds      = state_r.sec;
  assign out_minutes      = state_r.min;
  assign out_hours        = state_r.hour;
  assign out_day_of_month = state_r.day;
  assign out_month_number = state_r.month;
  assign out_set_field    = state_r.field;
  assign out_display_mode = state_r.mode;
  assign out_running      = (state_r.field == FIELD_RUN);

  // The time of day never leaves its legal range.
  a_time_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_seconds <= SEC_MAX && out_minutes <= MIN_MAX && out_hours <= HOUR_MAX))
    else $error("time field out of range");

  // The day stays within the length of the current month.
  a_day_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_day_of_month >= DAY_W'(1) &&
                   out_day_of_month <= month_len(out_month_number)))
    else $error("day outside current month");

  // A tick while a field is being set leaves the clock untouched.
  a_tick_frozen: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && s1_opcode_r == OP_TICK && state_r.field != FIELD_RUN) |=>
      (state_r == $past(state_r)))
    else $error("tick changed state while setting");

  // The result beat is loaded exactly when an input beat moves on.
  a_load: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_valid)
    else $error("result beat lost");

endmodule
